### hdl/srfd_pkg.sv
// Shared constants, result codes and state types of the sprite run-length frame decoder.
// Depends on nothing; the decode core and the top level import it.
package srfd_pkg;

   // Largest frame dimension; width and height register values clamp to it when used.
   localparam int MAX_DIM = 1024;

   localparam int DATA_W    = 8;
   localparam int STATUS_W  = 3;
   localparam int INDEX_W   = 20;
   localparam int COL_W     = 32;
   localparam int LIT_W     = 7;
   localparam int LEN_W     = 24;
   localparam int CFG_DIM_W = 11;
   localparam int DIM_W     = $clog2(MAX_DIM + 1);
   localparam int ROW_W     = $clog2(MAX_DIM);
   localparam int BASE_W    = ROW_W + DIM_W;
   localparam int TOTAL_W   = 2 * DIM_W;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLIPPED      = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_LENGTH = 2'd3;

   // Result codes
   localparam logic [STATUS_W-1:0] ST_CONSUMED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PIXEL    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DONE     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OVERRUN  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BOUNDS   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd5;
   localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd6;

   // Control byte codes
   localparam logic [DATA_W-1:0] EOL_CODE = 8'h80;
   localparam logic [DATA_W-1:0] RUN_MASK = 8'h7F;

   typedef struct packed {
      logic [CFG_DIM_W-1:0] frame_width;
      logic [CFG_DIM_W-1:0] frame_height;
      logic                 flipped;
      logic [LEN_W-1:0]     frame_length;
   } cfg_type;

   typedef struct packed {
      logic [LIT_W-1:0]   literal_left;
      logic [COL_W-1:0]   column;
      logic [ROW_W-1:0]   row;
      logic [BASE_W-1:0]  row_base;
      logic [LEN_W-1:0]   byte_count;
      logic [TOTAL_W-1:0] pixel_total;
      logic               finished;
   } state_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  pixel_index;
      logic [DATA_W-1:0]   pixel_value;
   } result_type;

   // Zero reads as one, anything above MAX_DIM reads as MAX_DIM.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (32'(v) > 32'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

endpackage

### hdl/sprite_rle_frame_decoder_top.sv
// Top level of the sprite run-length frame decoder: handshakes, configuration and registers.
// Depends on srfd_pkg and srfd_core.
//
//  channel  | direction | ports                                   | transfer when
//  ---------+-----------+-----------------------------------------+-----------------------
//  req      | in        | req_data_byte, req_frame_start          | req_valid & req_ready
//  rsp      | out       | rsp_status, rsp_pixel_index, rsp_pixel_value | rsp_valid & rsp_ready
//  csr      | in        | csr_index, csr_write_data               | csr_write_enable
//
// Each coded byte passes through the input register and then the result register. One
// byte is accepted and one result delivered every cycle while the result channel does not
// stall; the throughput is set by the single decode step between the two registers.
// Reset (synchronous, active high) clears both stages, loads the register defaults
// and leaves the decoder finished, so bytes answer "ignored" until a frame start.
// A stalled result holds both stages; req_ready drops only when both are full.
module sprite_rle_frame_decoder_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [srfd_pkg::DATA_W-1:0]        req_data_byte,
   input  logic                               req_frame_start,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [srfd_pkg::STATUS_W-1:0]      rsp_status,
   output logic [srfd_pkg::INDEX_W-1:0]       rsp_pixel_index,
   output logic [srfd_pkg::DATA_W-1:0]        rsp_pixel_value,
   input  logic                               csr_write_enable,
   input  logic [srfd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [srfd_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import srfd_pkg::*;

   // configuration registers
   cfg_type            cfg_ff;
   cfg_type            cfg_in;

   // input register stage
   logic               in_valid_ff;
   logic               in_valid_in;
   logic [DATA_W-1:0]  in_data_ff;
   logic               in_start_ff;

   // decoder state
   state_type          state_ff;
   state_type          state_in;

   // result register stage
   logic               out_valid_ff;
   logic               out_valid_in;
   result_type         out_ff;

   state_type          core_state;
   result_type         core_result;
   logic               out_free;
   logic               advance;
   logic               req_take;

   srfd_core u_core (
      .cfg         (cfg_ff),
      .state       (state_ff),
      .data_byte   (in_data_ff),
      .frame_start (in_start_ff),
      .state_next  (core_state),
      .result      (core_result)
   );

   // The result slot is free when empty or being drained this cycle.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);
   assign state_in     = advance ? core_state : state_ff;

   // Configuration writes land directly; the user must write only when idle (not enforced).
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  cfg_in.frame_width  = csr_write_data[CFG_DIM_W-1:0];
            CSR_FRAME_HEIGHT: cfg_in.frame_height = csr_write_data[CFG_DIM_W-1:0];
            CSR_FLIPPED:      cfg_in.flipped      = csr_write_data[0];
            CSR_FRAME_LENGTH: cfg_in.frame_length = csr_write_data[LEN_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width     <= CFG_DIM_W'(1);
         cfg_ff.frame_height    <= CFG_DIM_W'(1);
         cfg_ff.flipped         <= 1'b0;
         cfg_ff.frame_length    <= '0;
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
         state_ff.literal_left  <= '0;
         state_ff.column        <= '0;
         state_ff.row           <= '0;
         state_ff.row_base      <= '0;
         state_ff.byte_count    <= '0;
         state_ff.pixel_total   <= '0;
         state_ff.finished      <= 1'b1;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers: capture on transfer, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff  <= req_data_byte;
         in_start_ff <= req_frame_start;
      end
      if (advance) begin
         out_ff <= core_result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_ff.status;
   assign rsp_pixel_index = out_ff.pixel_index;
   assign rsp_pixel_value = out_ff.pixel_value;

endmodule

### hdl/srfd_core.sv
// Single-byte decode step: next decoder state and the result for one coded byte.
// Purely combinational; depends on srfd_pkg.
module srfd_core (
   input  srfd_pkg::cfg_type                 cfg,
   input  srfd_pkg::state_type               state,
   input  logic [srfd_pkg::DATA_W-1:0]       data_byte,
   input  logic                              frame_start,
   output srfd_pkg::state_type               state_next,
   output srfd_pkg::result_type              result
);
   import srfd_pkg::*;

   logic [DIM_W-1:0]   w;
   logic [DIM_W-1:0]   h;
   logic [DIM_W-1:0]   h_last;
   logic [ROW_W-1:0]   start_row;
   logic [ROW_W-1:0]   row_work;
   logic [ROW_W-1:0]   row_next;
   logic               row_load;
   logic               last_row;
   logic [TOTAL_W-1:0] total_prod;
   logic [BASE_W-1:0]  base_prod;
   logic [COL_W:0]     pixel_sum;
   logic [COL_W:0]     col_sum;
   logic [COL_W-1:0]   col_sat;
   logic [COL_W-1:0]   run_len;
   logic [LEN_W-1:0]   count_inc;
   state_type          work;

   assign w          = clamp_dim(cfg.frame_width);
   assign h          = clamp_dim(cfg.frame_height);
   assign h_last     = h - DIM_W'(1);
   assign start_row  = cfg.flipped ? '0 : ROW_W'(h_last);
   assign total_prod = TOTAL_W'(w) * TOTAL_W'(h);
   assign row_work   = frame_start ? start_row : state.row;
   assign last_row   = cfg.flipped ? (DIM_W'(row_work) >= h_last) : (row_work == '0);
   assign base_prod  = BASE_W'(row_next) * BASE_W'(w);

   // Literal pixels never follow a frame start within the same byte, so the
   // stored row base is the one in force here.
   assign pixel_sum  = {1'b0, state.column} + (COL_W+1)'(state.row_base);
   // A literal pixel advances the column by one, whatever its value; only a
   // control byte with bit 7 set, other than the end-of-line code, skips.
   assign run_len    = (work.literal_left == '0 && data_byte[7] && data_byte != EOL_CODE) ?
                       COL_W'(data_byte & RUN_MASK) : COL_W'(1);
   assign col_sum    = {1'b0, work.column} + {1'b0, run_len};
   assign col_sat    = col_sum[COL_W] ? '1 : col_sum[COL_W-1:0];
   assign count_inc  = work.byte_count + LEN_W'(1);

   always_comb begin
      work = state;
      if (frame_start) begin
         work.column       = '0;
         work.literal_left = '0;
         work.byte_count   = '0;
         work.pixel_total  = total_prod;
         work.finished     = 1'b0;
      end
      work.row = row_work;

      state_next         = work;
      row_next           = row_work;
      row_load           = frame_start;
      result.status      = ST_CONSUMED;
      result.pixel_index = '0;
      result.pixel_value = '0;

      if (work.finished) begin
         result.status = ST_IGNORED;
      end else if (work.byte_count >= cfg.frame_length) begin
         result.status       = ST_OVERRUN;
         state_next.finished = 1'b1;
      end else if (work.literal_left != '0) begin
         if ((COL_W+1)'(work.pixel_total) <= pixel_sum) begin
            result.status       = ST_BOUNDS;
            state_next.finished = 1'b1;
         end else begin
            result.status           = ST_PIXEL;
            result.pixel_index      = pixel_sum[INDEX_W-1:0];
            result.pixel_value      = data_byte;
            state_next.byte_count   = count_inc;
            state_next.column       = col_sat;
            state_next.literal_left = work.literal_left - LIT_W'(1);
         end
      end else if (data_byte == EOL_CODE) begin
         state_next.byte_count = count_inc;
         if (last_row) begin
            state_next.finished = 1'b1;
            result.status = (count_inc != cfg.frame_length) ? ST_MISMATCH : ST_DONE;
         end else begin
            row_next          = cfg.flipped ? row_work + ROW_W'(1) : row_work - ROW_W'(1);
            row_load          = 1'b1;
            state_next.column = '0;
         end
      end else if (data_byte[7]) begin
         state_next.byte_count = count_inc;
         state_next.column     = col_sat;
      end else if (data_byte != '0) begin
         state_next.byte_count   = count_inc;
         state_next.literal_left = data_byte[LIT_W-1:0];
      end

      state_next.row = row_next;
      if (row_load) begin
         state_next.row_base = base_prod;
      end
   end

endmodule

### dv/srfd_check_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the sprite run-length frame decoder testbench: predicts the result of each
// accepted coded byte and checks delivered results in order. Depends on srfd_pkg.
package srfd_check_pkg;
   import srfd_pkg::*;

   class frame_decode_scoreboard;
      cfg_type     regs;
      int unsigned literal_left;
      int unsigned column;
      int unsigned row;
      int unsigned row_base;
      int unsigned byte_count;
      int unsigned pixel_total;
      bit          finished;
      result_type  awaited_results[$];
      int unsigned failures;

      function new();
         regs              = '0;
         regs.frame_width  = CFG_DIM_W'(1);
         regs.frame_height = CFG_DIM_W'(1);
         literal_left      = 0;
         column            = 0;
         row               = 0;
         row_base          = 0;
         byte_count        = 0;
         pixel_total       = 0;
         finished          = 1'b1;
         failures          = 0;
      endfunction

      // zero counts as one, oversize counts as MAX_DIM
      function int unsigned dim_of(logic [CFG_DIM_W-1:0] v);
         if (v == '0) return 1;
         if (v > MAX_DIM) return MAX_DIM;
         return 32'(v);
      endfunction

      function int unsigned pending();
         return awaited_results.size();
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_FRAME_WIDTH:  regs.frame_width  = data[CFG_DIM_W-1:0];
            CSR_FRAME_HEIGHT: regs.frame_height = data[CFG_DIM_W-1:0];
            CSR_FLIPPED:      regs.flipped      = data[0];
            CSR_FRAME_LENGTH: regs.frame_length = data[LEN_W-1:0];
            default: ;
         endcase
      endfunction

      // advance the decoder copy by one coded byte and queue the answer it gives
      function void note_byte(logic [DATA_W-1:0] data_byte, logic frame_start);
         result_type      r;
         int unsigned     w;
         int unsigned     h;
         longint unsigned idx;
         longint unsigned sum;
         bit              last_row;
         r        = '0;
         r.status = ST_CONSUMED;
         w        = dim_of(regs.frame_width);
         h        = dim_of(regs.frame_height);
         if (frame_start) begin
            column       = 0;
            literal_left = 0;
            byte_count   = 0;
            row          = regs.flipped ? 0 : h - 1;
            row_base     = row * w;
            pixel_total  = w * h;
            finished     = 1'b0;
         end
         if (finished) begin
            r.status = ST_IGNORED;
         end else if (byte_count >= regs.frame_length) begin
            r.status = ST_OVERRUN;
            finished = 1'b1;
         end else if (literal_left != 0) begin
            idx = longint'(column) + row_base;
            if (idx >= pixel_total) begin
               r.status = ST_BOUNDS;
               finished = 1'b1;
            end else begin
               r.status      = ST_PIXEL;
               r.pixel_index = idx[INDEX_W-1:0];
               r.pixel_value = data_byte;
               byte_count++;
               if (column != 32'hFFFF_FFFF) column++;
               literal_left--;
            end
         end else if (data_byte == EOL_CODE) begin
            byte_count++;
            last_row = regs.flipped ? (row >= h - 1) : (row == 0);
            if (last_row) begin
               finished = 1'b1;
               r.status = (byte_count != regs.frame_length) ? ST_MISMATCH : ST_DONE;
            end else begin
               row      = regs.flipped ? row + 1 : row - 1;
               row_base = row * w;
               column   = 0;
            end
         end else if (data_byte[7]) begin
            byte_count++;
            sum    = longint'(column) + (data_byte & RUN_MASK);
            column = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
         end else if (data_byte != '0) begin
            byte_count++;
            literal_left = 32'(data_byte);
         end
         awaited_results = {awaited_results, r};
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (awaited_results.size() == 0) begin
            $error("result with no byte awaiting it: status %0d, pixel_index %0d, pixel_value %0d",
                   got.status, got.pixel_index, got.pixel_value);
            failures++;
            return;
         end
         want = awaited_results.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            failures++;
         end
         if (got.pixel_index !== want.pixel_index) begin
            $error("pixel_index: expected %0d, actual %0d", want.pixel_index, got.pixel_index);
            failures++;
         end
         if (got.pixel_value !== want.pixel_value) begin
            $error("pixel_value: expected %0d, actual %0d", want.pixel_value, got.pixel_value);
            failures++;
         end
      endfunction
   endclass

endpackage

### dv/testbench.sv
`timescale 1ns / 100ps
// Top of the sprite run-length frame decoder testbench: clock, reset, byte and result
// handshakes, register writes and the frame stimulus. Depends on srfd_pkg and srfd_check_pkg.
module testbench;
   import srfd_pkg::*;
   import srfd_check_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned ITEMS_TOTAL = 850;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic [DATA_W-1:0]      req_data_byte    = '0;
   logic                   req_frame_start  = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [INDEX_W-1:0]     rsp_pixel_index;
   logic [DATA_W-1:0]      rsp_pixel_value;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;

   // idle odds in percent for the byte sender and the result receiver
   int unsigned send_idle_pct = 31;
   int unsigned recv_idle_pct = 82;
   int unsigned items_sent    = 0;
   int unsigned cycle_count   = 0;

   frame_decode_scoreboard decoder_sb = new();

   sprite_rle_frame_decoder_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_pixel_index  (rsp_pixel_index),
      .rsp_pixel_value  (rsp_pixel_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // 4 ns clock: high for 2, low for 2
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Stop a hung run; the limit is many times the slowest legal run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Stall the result channel at random; change only on the falling edge.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
   end

   // Observe every register write, byte transfer and result transfer at the rising edge.
   // Register writes and byte transfers never share an edge, since writes happen only
   // once the decoder has drained.
   always @(posedge clock) begin : observe
      result_type delivered;
      if (!reset) begin
         if (csr_write_enable) begin
            decoder_sb.write_reg(csr_index, csr_write_data);
         end
         if (req_valid && req_ready) begin
            decoder_sb.note_byte(req_data_byte, req_frame_start);
         end
         if (rsp_valid && rsp_ready) begin
            delivered.status      = rsp_status;
            delivered.pixel_index = rsp_pixel_index;
            delivered.pixel_value = rsp_pixel_value;
            decoder_sb.check_result(delivered);
         end
      end
   end

   // Present one coded byte, possibly after a random gap, and hold it until the transfer.
   // Returns at the rising edge of the transfer with valid still high, so a following
   // call can keep valid up without lowering it in between.
   task automatic send_byte(logic [DATA_W-1:0] data_byte, logic frame_start);
      @(negedge clock);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= data_byte;
      req_frame_start <= frame_start;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Drop valid and hold off until every queued result has come back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (decoder_sb.pending() != 0) @(negedge clock);
   endtask

   task automatic write_one(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
   endtask

   // Write all four registers back to back; call only once drained.
   task automatic write_regs(logic [CFG_DIM_W-1:0] width_reg, logic [CFG_DIM_W-1:0] height_reg,
                             logic flip, logic [LEN_W-1:0] length_reg);
      write_one(CSR_FRAME_WIDTH, CSR_DATA_W'(width_reg));
      write_one(CSR_FRAME_HEIGHT, CSR_DATA_W'(height_reg));
      write_one(CSR_FLIPPED, CSR_DATA_W'(flip));
      write_one(CSR_FRAME_LENGTH, CSR_DATA_W'(length_reg));
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly small dimensions, now and then zero, one, the maximum or beyond it.
   function automatic logic [CFG_DIM_W-1:0] pick_dim(int unsigned common_hi);
      if ($urandom_range(9, 0) == 0) begin
         case ($urandom_range(3, 0))
            0:       return CFG_DIM_W'(0);
            1:       return CFG_DIM_W'(1);
            2:       return CFG_DIM_W'(MAX_DIM);
            default: return CFG_DIM_W'(2047);
         endcase
      end
      return CFG_DIM_W'($urandom_range(common_hi, 1));
   endfunction

   // Build one mostly well-formed frame with random content, pick a length that usually
   // matches it, and send it. Now and then: inject a stray byte, cut the frame short,
   // restart it mid-stream, change the registers partway, or trail an extra byte.
   task automatic random_frame();
      logic [DATA_W-1:0]    body[$];
      logic [CFG_DIM_W-1:0] width_reg;
      logic [CFG_DIM_W-1:0] height_reg;
      logic [LEN_W-1:0]     length_reg;
      int unsigned          w;
      int unsigned          h;
      int unsigned          rows;
      int unsigned          ops;
      int unsigned          run;
      int unsigned          skip;
      int unsigned          counted;
      int unsigned          split;
      int unsigned          cut;
      width_reg  = pick_dim(12);
      height_reg = pick_dim(6);
      w = decoder_sb.dim_of(width_reg);
      h = decoder_sb.dim_of(height_reg);
      // tall frames get only a few rows; the next frame start abandons them
      rows    = (h > 6) ? $urandom_range(4, 1) : h;
      counted = 0;
      for (int r = 0; r < rows; r++) begin
         ops = $urandom_range(3, 0);
         for (int k = 0; k < ops; k++) begin
            case ($urandom_range(5, 0))
               0: begin
                  skip = $urandom_range((w < 127) ? w : 127, 1);
                  body = {body, EOL_CODE | DATA_W'(skip)};
                  counted++;
               end
               1: body = {body, DATA_W'(0)};
               default: begin
                  run = ($urandom_range(19, 0) == 0) ? $urandom_range(127, 1)
                                                     : $urandom_range((w < 8) ? w : 8, 1);
                  body = {body, DATA_W'(run)};
                  repeat (run) body = {body, DATA_W'($urandom_range(255, 0))};
                  counted += run + 1;
               end
            endcase
         end
         body = {body, EOL_CODE};
         counted++;
      end
      if ($urandom_range(9, 0) == 0) begin
         body.insert($urandom_range(body.size(), 0), DATA_W'($urandom_range(255, 0)));
      end
      if ($urandom_range(19, 0) == 0) begin
         cut = $urandom_range(body.size(), 1);
         while (body.size() > cut) void'(body.pop_back());
      end
      case ($urandom_range(19, 0))
         0:       length_reg = '0;
         1:       length_reg = '1;
         2, 3:    length_reg = LEN_W'(counted - 1);
         4, 5:    length_reg = LEN_W'(counted + 1);
         6:       length_reg = LEN_W'($urandom_range(24'hFF_FFFF, 0));
         7:       length_reg = LEN_W'($urandom_range(counted + 4, 0));
         default: length_reg = LEN_W'(counted);
      endcase
      drain();
      write_regs(width_reg, height_reg, 1'($urandom_range(1, 0)), length_reg);
      split = (body.size() > 1 && $urandom_range(6, 0) == 0) ?
              $urandom_range(body.size() - 1, 1) : body.size();
      foreach (body[i]) begin
         if (i == split) begin
            // change geometry and direction with the frame partway done
            drain();
            write_regs(pick_dim(12), pick_dim(6), 1'($urandom_range(1, 0)), length_reg);
         end
         send_byte(body[i], (i == 0) || ($urandom_range(39, 0) == 0));
      end
      if ($urandom_range(3, 0) == 0) begin
         send_byte(DATA_W'($urandom_range(255, 0)), 1'b0);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: no frame started yet, so the byte is ignored.
      send_byte(8'hFF, 1'b0);

      // Zero length and zero dimensions: the first byte overruns, the next is ignored.
      drain();
      write_regs('0, '0, 1'b0, '0);
      send_byte(EOL_CODE, 1'b1);
      send_byte(8'h05, 1'b0);

      // Bottom-up frame with literals that look like control bytes, a zero control
      // byte, a skip, and one byte short of the length at the end.
      drain();
      write_regs(CFG_DIM_W'(3), CFG_DIM_W'(2), 1'b0, LEN_W'(9));
      send_byte(8'h02, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h81, 1'b0);
      send_byte(EOL_CODE, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(EOL_CODE, 1'b0);

      // Literal run past the last pixel: out of bounds, then ignored.
      drain();
      write_regs(CFG_DIM_W'(2), CFG_DIM_W'(1), 1'b1, '1);
      send_byte(8'h03, 1'b1);
      send_byte(8'h11, 1'b0);
      send_byte(8'h22, 1'b0);
      send_byte(8'h33, 1'b0);
      send_byte(8'h44, 1'b0);

      // Top-down frame whose length matches exactly.
      drain();
      write_regs(CFG_DIM_W'(1), CFG_DIM_W'(2), 1'b1, LEN_W'(4));
      send_byte(8'h01, 1'b1);
      send_byte(8'h5A, 1'b0);
      send_byte(EOL_CODE, 1'b0);
      send_byte(EOL_CODE, 1'b0);

      // Oversize dimensions clamp; the first pixel lands on the highest row base.
      drain();
      write_regs(CFG_DIM_W'(2047), CFG_DIM_W'(2047), 1'b0, '1);
      send_byte(8'h01, 1'b1);
      send_byte(8'hA5, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(EOL_CODE, 1'b0);

      // Random frames: slow receiver, then slow sender, then both at full rate.
      while (items_sent < ITEMS_TOTAL / 3) random_frame();
      send_idle_pct = 82;
      recv_idle_pct = 31;
      while (items_sent < 2 * ITEMS_TOTAL / 3) random_frame();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (items_sent < ITEMS_TOTAL) random_frame();

      // Let the last results out, then let the pipeline settle before the final check.
      drain();
      repeat (8) @(posedge clock);
      if (decoder_sb.failures == 0 && decoder_sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
